FILE: design/mfu_pkg.sv
// Shared constants, stage record and helpers for the Mandelbox fold unit.
// No dependencies; every other design file imports this package.
package mfu_pkg;

    localparam int FRAC_BITS = 16;
    // sphere factor: 32 integer bits and FRAC_BITS fraction bits
    localparam int QW        = 32 + FRAC_BITS;
    // width of a squared 31-bit radius
    localparam int SQW       = 62;
    localparam logic [15:0] NINE_TENTHS = 16'd58982;

    // pipeline stage numbers
    localparam int ST_SQ   = 1;
    localparam int ST_CMP  = 2;
    localparam int ST_DIV0 = 3;
    localparam int ST_MUL  = ST_DIV0 + QW;
    localparam int ST_SUM  = ST_MUL + 1;
    localparam int ST_OUT  = ST_SUM + 1;
    localparam int NSTG    = ST_OUT + 1;

    localparam int IN_TDATA_W  = 192;
    localparam int OUT_TDATA_W = 160;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOX_LIMIT    = 2'd0,
        REG_BOX_VALUE    = 2'd1,
        REG_SPHERE_OUTER = 2'd2,
        REG_SPHERE_INNER = 2'd3
    } t_reg_idx;

    typedef enum logic {
        CMD_BOX    = 1'b0,
        CMD_SPHERE = 1'b1
    } t_cmd;

    // one item as it moves down the pipeline
    typedef struct packed {
        t_cmd                         cmd;
        logic                         folded;
        logic [1:0]                   ncol;
        logic [2:0][31:0]             p;
        logic [30:0]                  de;
        logic [30:0]                  color;
        logic [30:0]                  radius;
        logic [SQW-1:0]               r2;
        logic [SQW-1:0]               o2;
        logic [SQW-1:0]               n2;
        logic [SQW-1:0]               num;
        logic [SQW-1:0]               den;
        logic [SQW-1:0]               rem;
        logic [QW-1:0]                q;
        logic                         ovf;
        logic [3:0]                   neg;
        logic [3:0][63:0]             ph;
        logic [3:0][31+FRAC_BITS:0]   pl;
    } t_stg;

    // colour times 0.9, truncated
    function automatic logic [30:0] scale_color(input logic [30:0] c);
        logic [46:0] prod;
        prod = {16'b0, c} * {31'b0, NINE_TENTHS};
        return prod[46:16];
    endfunction

    // clamp a 34-bit signed value into 32 bits
    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        logic [31:0] res;
        if (v > 34'sd2147483647) begin
            res = 32'h7FFF_FFFF;
        end else if (v < -34'sd2147483648) begin
            res = 32'h8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

FILE: design/mfu_div_step.sv
// One restoring division step: shift in a dividend bit, trial subtract.
// Depends on mfu_pkg for the remainder width.
module mfu_div_step (
    input  logic [mfu_pkg::SQW-1:0] i_rem,
    input  logic [mfu_pkg::SQW-1:0] i_den,
    input  logic                    i_dbit,
    output logic [mfu_pkg::SQW-1:0] o_rem,
    output logic                    o_qbit
);
    import mfu_pkg::*;

    logic [SQW:0] w_sh;
    logic [SQW:0] w_diff;

    // shift and subtract; keep the remainder when the divisor does not fit
    assign w_sh   = {i_rem, i_dbit};
    assign w_diff = w_sh - {1'b0, i_den};
    assign o_qbit = (w_sh >= {1'b0, i_den});
    assign o_rem  = o_qbit ? w_diff[SQW-1:0] : w_sh[SQW-1:0];

endmodule

FILE: design/mandelbox_fold_unit.sv
// Top level of the Mandelbox fold unit: box fold, sphere fold, pipelined
// factor division and scaling. Depends on mfu_pkg and mfu_div_step.
//
//  channel   direction  signals                               beat carries
//  s         in         i_s_tvalid o_s_tready i_s_tdata/tuser one point, cmd in tuser
//  m         out        o_m_tvalid i_m_tready o_m_tdata/tuser folded point, flag in tuser
//  cfg       in         i_cfg_valid o_cfg_ready index/data    one register write
//
// The pipeline has one stage per quotient bit of the factor divider plus
// six; a new beat is taken every cycle while no output stall backs up the stages.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles close up under a stall and nothing is dropped or repeated.
// Reset (synchronous, active low) clears the valid bits and restores the
// register defaults; there is no clearing pass.
module mandelbox_fold_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // x[31:0] y[63:32] z[95:64] radius[126:96] de[157:127] color[188:158]
    input  logic [mfu_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    // cmd
    input  logic                                i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // x[31:0] y[63:32] z[95:64] de[126:96] color[157:127]
    output logic [mfu_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    // folded
    output logic                                o_m_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mfu_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [30:0]                         i_cfg_data
);
    import mfu_pkg::*;

    logic [30:0] r_box_limit;
    logic [30:0] r_box_value;
    logic [30:0] r_sphere_outer;
    logic [30:0] r_sphere_inner;

    t_stg r_s [NSTG];
    t_stg n_s [NSTG];
    logic r_v [NSTG];
    logic adv [NSTG+1];

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_limit    <= 31'd65536;
            r_box_value    <= 31'd131072;
            r_sphere_outer <= 31'd65536;
            r_sphere_inner <= 31'd32768;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_BOX_LIMIT:    r_box_limit    <= i_cfg_data;
                REG_BOX_VALUE:    r_box_value    <= i_cfg_data;
                REG_SPHERE_OUTER: r_sphere_outer <= i_cfg_data;
                REG_SPHERE_INNER: r_sphere_inner <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // advance chain from the output back to the input
    assign adv[NSTG]  = i_m_tready;
    assign o_s_tready = adv[0];

    genvar k;
    generate
        for (k = 0; k < NSTG; k++) begin : g_stg
            assign adv[k] = !r_v[k] || adv[k+1];

            if (k == 0) begin : g_box
                // unpack the beat and apply the box fold
                always_comb begin
                    logic signed [32:0] ps;
                    logic signed [32:0] lim;
                    logic signed [33:0] ps34;
                    logic signed [33:0] val;
                    n_s[k]        = '0;
                    n_s[k].cmd    = t_cmd'(i_s_tuser);
                    n_s[k].p[0]   = i_s_tdata[31:0];
                    n_s[k].p[1]   = i_s_tdata[63:32];
                    n_s[k].p[2]   = i_s_tdata[95:64];
                    n_s[k].radius = i_s_tdata[126:96];
                    n_s[k].de     = i_s_tdata[157:127];
                    n_s[k].color  = i_s_tdata[188:158];
                    lim = $signed({2'b0, r_box_limit});
                    val = $signed({3'b0, r_box_value});
                    for (int a = 0; a < 3; a++) begin
                        ps   = $signed({n_s[k].p[a][31], n_s[k].p[a]});
                        ps34 = $signed({{2{n_s[k].p[a][31]}}, n_s[k].p[a]});
                        if (n_s[k].cmd == CMD_BOX) begin
                            if (ps > lim) begin
                                n_s[k].p[a]   = sat32(val - ps34);
                                n_s[k].ncol   = n_s[k].ncol + 2'd1;
                                n_s[k].folded = 1'b1;
                            end else if (ps < -lim) begin
                                n_s[k].p[a]   = sat32(-val - ps34);
                                n_s[k].ncol   = n_s[k].ncol + 2'd1;
                                n_s[k].folded = 1'b1;
                            end
                        end
                    end
                end
            end else if (k == ST_SQ) begin : g_sq
                // square the radii
                always_comb begin
                    n_s[k]    = r_s[k-1];
                    n_s[k].r2 = {31'b0, r_s[k-1].radius} * {31'b0, r_s[k-1].radius};
                    n_s[k].o2 = {31'b0, r_sphere_outer} * {31'b0, r_sphere_outer};
                    n_s[k].n2 = {31'b0, r_sphere_inner} * {31'b0, r_sphere_inner};
                end
            end else if (k == ST_CMP) begin : g_cmp
                // pick the sphere branch and the divisor, flag a saturated factor
                always_comb begin
                    n_s[k]     = r_s[k-1];
                    n_s[k].num = r_s[k-1].o2;
                    n_s[k].den = r_s[k-1].r2;
                    if (r_s[k-1].cmd == CMD_SPHERE) begin
                        n_s[k].folded = 1'b0;
                        n_s[k].ncol   = 2'd0;
                        if (r_s[k-1].r2 < r_s[k-1].n2) begin
                            n_s[k].den    = r_s[k-1].n2;
                            n_s[k].folded = 1'b1;
                            n_s[k].ncol   = 2'd1;
                        end else if (r_s[k-1].r2 < r_s[k-1].o2) begin
                            n_s[k].folded = 1'b1;
                            n_s[k].ncol   = 2'd1;
                        end
                    end
                    n_s[k].ovf = (n_s[k].den == '0) ||
                                 ({32'b0, n_s[k].num[SQW-1:32]} >= n_s[k].den);
                    n_s[k].rem = {32'b0, n_s[k].num[SQW-1:32]};
                    n_s[k].q   = '0;
                end
            end else if (k < ST_MUL) begin : g_div
                localparam int B = QW - 1 - (k - ST_DIV0);
                logic           w_dbit;
                logic [SQW-1:0] w_rem;
                logic           w_qbit;

                if (B >= FRAC_BITS) begin : g_nb
                    assign w_dbit = r_s[k-1].num[B-FRAC_BITS];
                end else begin : g_zb
                    assign w_dbit = 1'b0;
                end

                mfu_div_step u_step (
                    .i_rem  (r_s[k-1].rem),
                    .i_den  (r_s[k-1].den),
                    .i_dbit (w_dbit),
                    .o_rem  (w_rem),
                    .o_qbit (w_qbit)
                );

                always_comb begin
                    n_s[k]      = r_s[k-1];
                    n_s[k].rem  = w_rem;
                    n_s[k].q[B] = w_qbit;
                end
            end else if (k == ST_MUL) begin : g_mul
                // magnitudes times the integer and fraction parts of the factor
                always_comb begin
                    logic [QW-1:0]        f;
                    logic [31:0]          hi;
                    logic [FRAC_BITS-1:0] lo;
                    logic [31:0]          mag;
                    n_s[k] = r_s[k-1];
                    f  = r_s[k-1].ovf ? '1 : r_s[k-1].q;
                    hi = f[QW-1:FRAC_BITS];
                    lo = f[FRAC_BITS-1:0];
                    for (int l = 0; l < 4; l++) begin
                        if (l < 3) begin
                            n_s[k].neg[l] = r_s[k-1].p[l][31];
                            mag = r_s[k-1].p[l][31] ? (~r_s[k-1].p[l] + 32'd1)
                                                    : r_s[k-1].p[l];
                        end else begin
                            n_s[k].neg[l] = 1'b0;
                            mag = {1'b0, r_s[k-1].de};
                        end
                        n_s[k].ph[l] = {32'b0, mag} * {32'b0, hi};
                        n_s[k].pl[l] = {{FRAC_BITS{1'b0}}, mag} * {32'b0, lo};
                    end
                    if (r_s[k-1].ncol >= 2'd1) begin
                        n_s[k].color = scale_color(r_s[k-1].color);
                    end
                end
            end else if (k == ST_SUM) begin : g_sum
                // add the partial products, saturate, restore the sign
                always_comb begin
                    logic [64:0] sum;
                    logic [64:0] cap;
                    logic [31:0] m;
                    n_s[k] = r_s[k-1];
                    for (int l = 0; l < 4; l++) begin
                        sum = {1'b0, r_s[k-1].ph[l]} +
                              65'(r_s[k-1].pl[l] >> FRAC_BITS);
                        cap = r_s[k-1].neg[l] ? 65'h8000_0000 : 65'h7FFF_FFFF;
                        m   = (sum > cap) ? cap[31:0] : sum[31:0];
                        if (r_s[k-1].cmd == CMD_SPHERE && r_s[k-1].folded) begin
                            if (l < 3) begin
                                n_s[k].p[l] = r_s[k-1].neg[l] ? (~m + 32'd1) : m;
                            end else begin
                                n_s[k].de = m[30:0];
                            end
                        end
                    end
                    if (r_s[k-1].ncol >= 2'd2) begin
                        n_s[k].color = scale_color(r_s[k-1].color);
                    end
                end
            end else begin : g_out
                // last colour scaling for a point folded on all three axes
                always_comb begin
                    n_s[k] = r_s[k-1];
                    if (r_s[k-1].ncol == 2'd3) begin
                        n_s[k].color = scale_color(r_s[k-1].color);
                    end
                end
            end

            // clear valid bits under reset, advance them with the stage
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (adv[k]) begin
                    r_v[k] <= (k == 0) ? i_s_tvalid : r_v[(k == 0) ? 0 : k-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (adv[k]) begin
                    r_s[k] <= n_s[k];
                end
            end
        end
    endgenerate

    // drive the result beat from the last stage
    assign o_m_tvalid = r_v[NSTG-1];
    assign o_m_tdata  = {2'b0, r_s[NSTG-1].color, r_s[NSTG-1].de,
                         r_s[NSTG-1].p[2], r_s[NSTG-1].p[1], r_s[NSTG-1].p[0]};
    assign o_m_tuser  = r_s[NSTG-1].folded;

endmodule

FILE: design/mfu_checker.sv
// Port-level checks for the Mandelbox fold unit, bound to the top level.
// Depends on mfu_pkg and mandelbox_fold_unit.
module mfu_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_s_tready,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [mfu_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    input logic                             o_m_tuser
);
    import mfu_pkg::*;

    // hold a stalled result beat unchanged
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result beat changed while stalled");

    // an empty or draining output stage must let the input advance
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_tvalid || i_m_tready) |-> o_s_tready)
        else $error("input stalled while output can move");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind mandelbox_fold_unit mfu_checker u_mfu_checker (.*);

FILE: sim/mandelbox_fold_unit_test.sv
// Self-checking testbench for mandelbox_fold_unit: box and sphere folds
// predicted in the bench, compared beat by beat. Depends on mfu_pkg.
`timescale 1ns / 1ps

module mandelbox_fold_unit_test;
    import mfu_pkg::*;

    localparam int LATENCY = 54;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [30:0] de;
        logic [30:0] color;
        logic        folded;
    } t_fold_out;

    typedef struct {
        t_cmd        cmd;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [30:0] radius;
        logic [30:0] de;
        logic [30:0] color;
        logic        has_fixed;
        t_fold_out   fixed_res;
    } t_point_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;
    logic                   i_s_tuser;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tuser;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [30:0]            i_cfg_data;

    mandelbox_fold_unit dut (.*);

    // bench copy of the registers
    logic [30:0] lim_q, val_q, outer_q, inner_q;

    t_fold_out folds_due[$];
    int  n_fail;
    int  n_items;
    int  n_beats_out;
    int  idle_gap_pct;
    int  stall_pct;
    int  quiet_cycles;
    bit  hold_off;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // 0.9 as 58982/65536, truncated
    function automatic logic [30:0] nine_tenths(input logic [30:0] c);
        logic [63:0] p;
        p = 64'(c) * 64'd58982;
        return p[46:16];
    endfunction

    // unsigned num/den with FRAC_BITS fraction bits, saturating
    function automatic logic [63:0] fold_factor(input logic [63:0] num,
                                                input logic [63:0] den);
        logic [63:0] fmax, q, rem, frac;
        fmax = (64'd1 << (32 + FRAC_BITS)) - 64'd1;
        if (den == 0) return fmax;
        q = num / den;
        if (q > 64'hFFFF_FFFF) return fmax;
        rem = num % den;
        frac = 0;
        for (int i = 0; i < FRAC_BITS; i++) begin
            rem = rem << 1;
            frac = frac << 1;
            if (rem >= den) begin
                rem = rem - den;
                frac[0] = 1'b1;
            end
        end
        return (q << FRAC_BITS) | frac;
    endfunction

    function automatic logic [63:0] scale_mag(input logic [63:0] mag,
                                              input logic [63:0] f,
                                              input logic [63:0] cap);
        logic [127:0] r;
        r = 128'(mag) * 128'(f >> FRAC_BITS)
            + ((128'(mag) * 128'(f & ((64'd1 << FRAC_BITS) - 1))) >> FRAC_BITS);
        return (r > 128'(cap)) ? cap : r[63:0];
    endfunction

    function automatic logic [31:0] scale_axis(input logic [31:0] v,
                                               input logic [63:0] f);
        logic [63:0] m;
        if (v[31]) begin
            m = scale_mag(64'(-$signed(v)) & 64'hFFFF_FFFF, f, 64'h8000_0000);
            return 32'(-m);
        end
        m = scale_mag(64'(v), f, 64'h7FFF_FFFF);
        return m[31:0];
    endfunction

    function automatic logic [31:0] sat_axis(input longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic t_fold_out predict_fold(input t_point_row pt);
        t_fold_out   r;
        logic [31:0] axis[3];
        longint      a, lim, val;
        logic [63:0] r2, o2, n2, f;
        axis[0] = pt.x;
        axis[1] = pt.y;
        axis[2] = pt.z;
        r.de = pt.de;
        r.color = pt.color;
        r.folded = 1'b0;
        if (pt.cmd == CMD_BOX) begin
            lim = longint'(lim_q);
            val = longint'(val_q);
            for (int i = 0; i < 3; i++) begin
                a = longint'($signed(axis[i]));
                if (a > lim) begin
                    axis[i] = sat_axis(val - a);
                    r.color = nine_tenths(r.color);
                    r.folded = 1'b1;
                end else if (a < -lim) begin
                    axis[i] = sat_axis(-val - a);
                    r.color = nine_tenths(r.color);
                    r.folded = 1'b1;
                end
            end
        end else begin
            r2 = 64'(pt.radius) * 64'(pt.radius);
            o2 = 64'(outer_q) * 64'(outer_q);
            n2 = 64'(inner_q) * 64'(inner_q);
            f = 0;
            if (r2 < n2) begin
                f = fold_factor(o2, n2);
                r.folded = 1'b1;
            end else if (r2 < o2) begin
                f = fold_factor(o2, r2);
                r.folded = 1'b1;
            end
            if (r.folded) begin
                for (int i = 0; i < 3; i++) axis[i] = scale_axis(axis[i], f);
                r.de = 31'(scale_mag(64'(pt.de), f, 64'h7FFF_FFFF));
                r.color = nine_tenths(r.color);
            end
        end
        r.x = axis[0];
        r.y = axis[1];
        r.z = axis[2];
        return r;
    endfunction

    // leave the write channel valid; the caller drops it after the last write
    task automatic write_reg(input t_reg_idx idx, input logic [30:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_BOX_LIMIT:    lim_q   = data;
            REG_BOX_VALUE:    val_q   = data;
            REG_SPHERE_OUTER: outer_q = data;
            REG_SPHERE_INNER: inner_q = data;
            default: ;
        endcase
    endtask

    // drop valid only while idling, so beats can follow back to back
    task automatic send_point(input t_point_row pt);
        while ($urandom_range(99) < idle_gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= pt.cmd;
        i_s_tdata  <= {3'b0, pt.color, pt.de, pt.radius, pt.z, pt.y, pt.x};
        do @(posedge i_clk); while (!o_s_tready);
        folds_due.push_back(pt.has_fixed ? pt.fixed_res : predict_fold(pt));
        n_items++;
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (folds_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_axis();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom();
            default: return 32'($signed($urandom_range(400000)) - 200000);
        endcase
    endfunction

    function automatic t_point_row rand_point();
        t_point_row pt;
        pt.cmd = t_cmd'($urandom_range(1));
        pt.x = rand_axis();
        pt.y = rand_axis();
        pt.z = rand_axis();
        pt.radius = ($urandom_range(7) == 0) ? 31'($urandom()) : 31'($urandom_range(90000));
        pt.de = ($urandom_range(3) == 0) ? 31'($urandom()) : 31'($urandom_range(300000));
        pt.color = 31'($urandom());
        pt.has_fixed = 1'b0;
        pt.fixed_res = '0;
        return pt;
    endfunction

    // receiver stall and output check
    always @(posedge i_clk) begin
        t_fold_out got, want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got = {o_m_tdata[31:0], o_m_tdata[63:32], o_m_tdata[95:64],
                       o_m_tdata[126:96], o_m_tdata[157:127], o_m_tuser};
                n_beats_out++;
                if (folds_due.size() == 0) begin
                    $display("%0t: unexpected beat %h", $realtime, got);
                    n_fail++;
                end else begin
                    want = folds_due.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected %h actual %h", $realtime, want, got);
                        n_fail++;
                    end
                end
            end
            i_m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog on accepted beats
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready) || hold_off) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        t_point_row rows[$];
        t_point_row pt;
        t_fold_out  pass_through;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_BOX_LIMIT;
        i_cfg_data = '0;
        n_fail = 0;
        n_items = 0;
        n_beats_out = 0;
        quiet_cycles = 0;
        hold_off = 1'b0;
        idle_gap_pct = 0;
        stall_pct = 0;
        lim_q = 31'd65536;
        val_q = 31'd131072;
        outer_q = 31'd65536;
        inner_q = 31'd32768;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows: reset defaults, extremes, each branch
        pt = '{CMD_BOX, 32'd0, 32'd0, 32'd0, 31'd0, 31'd5, 31'd1000, 1'b1,
               '{32'd0, 32'd0, 32'd0, 31'd5, 31'd1000, 1'b0}};
        rows.push_back(pt);
        // x just over the limit: 2.0 - 1.5 = 0.5, colour times 0.9
        pt = '{CMD_BOX, 32'd98304, 32'd0, 32'd0, 31'd0, 31'd7, 31'd65536, 1'b1,
               '{32'd32768, 32'd0, 32'd0, 31'd7, 31'd58982, 1'b1}};
        rows.push_back(pt);
        // radius above outer: pass through
        pass_through = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd3, 31'h7FFF_FFFF,
                         31'h7FFF_FFFF, 1'b0};
        pt = '{CMD_SPHERE, 32'h7FFF_FFFF, 32'h8000_0000, 32'd3, 31'h7FFF_FFFF,
               31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1, pass_through};
        rows.push_back(pt);
        for (int i = 0; i < 8; i++) begin
            pt = rand_point();
            pt.cmd = t_cmd'(i[0]);
            pt.x = (i < 4) ? 32'h7FFF_FFFF : 32'h8000_0000;
            pt.y = (i < 4) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            pt.radius = (i[1]) ? 31'd10000 : 31'd50000;
            rows.push_back(pt);
        end
        pt = rand_point();
        pt.cmd = CMD_SPHERE;
        pt.radius = 31'd0;
        pt.de = 31'h7FFF_FFFF;
        rows.push_back(pt);
        foreach (rows[i]) send_point(rows[i]);
        drain_results();

        // several register settings, extremes included
        for (int phase = 0; phase < 8; phase++) begin
            hold_off = 1'b1;
            repeat (LATENCY + 4) @(posedge i_clk);
            hold_off = 1'b0;
            case (phase % 4)
                0: begin idle_gap_pct = 0;  stall_pct = 0;  end
                1: begin idle_gap_pct = 79; stall_pct = 0;  end
                2: begin idle_gap_pct = 0;  stall_pct = 79; end
                default: begin idle_gap_pct = 23; stall_pct = 23; end
            endcase
            case (phase)
                0: begin
                    // zero inner radius with a zero radius: zero divisor
                    write_reg(REG_SPHERE_INNER, 31'd0);
                end
                1: begin
                    write_reg(REG_BOX_LIMIT, 31'd0);
                    write_reg(REG_BOX_VALUE, 31'h7FFF_FFFF);
                    write_reg(REG_SPHERE_OUTER, 31'h7FFF_FFFF);
                    write_reg(REG_SPHERE_INNER, 31'd1);
                end
                2: begin
                    write_reg(REG_BOX_LIMIT, 31'h7FFF_FFFF);
                    write_reg(REG_BOX_VALUE, 31'd0);
                    write_reg(REG_SPHERE_INNER, 31'h7FFF_FFFF);
                end
                default: begin
                    write_reg(REG_BOX_LIMIT, 31'($urandom_range(200000)));
                    write_reg(REG_BOX_VALUE, 31'($urandom_range(400000)));
                    write_reg(REG_SPHERE_OUTER, 31'($urandom_range(100000)));
                    write_reg(REG_SPHERE_INNER, 31'($urandom_range(60000)));
                end
            endcase
            i_cfg_valid <= 1'b0;
            for (int i = 0; i < 88; i++) begin
                pt = rand_point();
                if (phase == 0 && i == 0) begin
                    pt.cmd = CMD_SPHERE;
                    pt.radius = 31'd0;
                end
                send_point(pt);
            end
            // hold the sender until the pipe is empty
            drain_results();
        end

        hold_off = 1'b1;
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Sent %0d points over 8 register settings, %0d results checked",
                 n_items, n_beats_out);
        if (n_fail == 0 && folds_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
